FILE: rtl/ftpr_pkg.sv
// Shared types, constants and the 5x7 glyph ROM for the character pixel renderer.
// No dependencies.
package ftpr_pkg;

  localparam int unsigned CellW      = 6;
  localparam int unsigned CellH      = 8;
  localparam int unsigned GlyphCols  = 5;
  localparam logic [7:0]  FirstCode  = 8'h20;
  localparam logic [7:0]  LastCode   = 8'h7E;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    REG_FG_COLOR   = 2'd0,
    REG_BG_COLOR   = 2'd1,
    REG_COL_OFFSET = 2'd2,
    REG_ROW_OFFSET = 2'd3
  } reg_idx_e;

  // column c of the glyph at index c, bit r is row r
  typedef logic [0:GlyphCols-1][6:0] glyph_t;

  typedef struct packed {
    logic [15:0] cell_x;
    logic [15:0] cell_y;
    glyph_t      glyph;
  } cell_t;

  typedef struct packed {
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [7:0]  col_offset;
    logic [7:0]  row_offset;
  } cfg_t;

  function automatic glyph_t glyph_rom(input logic [6:0] idx);
    glyph_t g;
    unique case (idx)
      7'd0:  g = '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
      7'd1:  g = '{7'h00, 7'h00, 7'h5F, 7'h00, 7'h00};
      7'd2:  g = '{7'h00, 7'h07, 7'h00, 7'h07, 7'h00};
      7'd3:  g = '{7'h14, 7'h7F, 7'h14, 7'h7F, 7'h14};
      7'd4:  g = '{7'h24, 7'h2A, 7'h7F, 7'h2A, 7'h12};
      7'd5:  g = '{7'h23, 7'h13, 7'h08, 7'h64, 7'h62};
      7'd6:  g = '{7'h36, 7'h49, 7'h55, 7'h22, 7'h50};
      7'd7:  g = '{7'h00, 7'h05, 7'h03, 7'h00, 7'h00};
      7'd8:  g = '{7'h00, 7'h1C, 7'h22, 7'h41, 7'h00};
      7'd9:  g = '{7'h00, 7'h41, 7'h22, 7'h1C, 7'h00};
      7'd10: g = '{7'h08, 7'h2A, 7'h1C, 7'h2A, 7'h08};
      7'd11: g = '{7'h08, 7'h08, 7'h3E, 7'h08, 7'h08};
      7'd12: g = '{7'h00, 7'h50, 7'h30, 7'h00, 7'h00};
      7'd13: g = '{7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
      7'd14: g = '{7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
      7'd15: g = '{7'h20, 7'h10, 7'h08, 7'h04, 7'h02};
      7'd16: g = '{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
      7'd17: g = '{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
      7'd18: g = '{7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
      7'd19: g = '{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31};
      7'd20: g = '{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
      7'd21: g = '{7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
      7'd22: g = '{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
      7'd23: g = '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
      7'd24: g = '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      7'd25: g = '{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
      7'd26: g = '{7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
      7'd27: g = '{7'h00, 7'h56, 7'h36, 7'h00, 7'h00};
      7'd28: g = '{7'h00, 7'h08, 7'h14, 7'h22, 7'h41};
      7'd29: g = '{7'h14, 7'h14, 7'h14, 7'h14, 7'h14};
      7'd30: g = '{7'h41, 7'h22, 7'h14, 7'h08, 7'h00};
      7'd31: g = '{7'h02, 7'h01, 7'h51, 7'h09, 7'h06};
      7'd32: g = '{7'h32, 7'h49, 7'h79, 7'h41, 7'h3E};
      7'd33: g = '{7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
      7'd34: g = '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
      7'd35: g = '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
      7'd36: g = '{7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
      7'd37: g = '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
      7'd38: g = '{7'h7F, 7'h09, 7'h09, 7'h01, 7'h01};
      7'd39: g = '{7'h3E, 7'h41, 7'h41, 7'h51, 7'h32};
      7'd40: g = '{7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
      7'd41: g = '{7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
      7'd42: g = '{7'h20, 7'h40, 7'h41, 7'h3F, 7'h01};
      7'd43: g = '{7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
      7'd44: g = '{7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
      7'd45: g = '{7'h7F, 7'h02, 7'h04, 7'h02, 7'h7F};
      7'd46: g = '{7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F};
      7'd47: g = '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
      7'd48: g = '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
      7'd49: g = '{7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E};
      7'd50: g = '{7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
      7'd51: g = '{7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
      7'd52: g = '{7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
      7'd53: g = '{7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
      7'd54: g = '{7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
      7'd55: g = '{7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F};
      7'd56: g = '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
      7'd57: g = '{7'h03, 7'h04, 7'h78, 7'h04, 7'h03};
      7'd58: g = '{7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
      7'd59: g = '{7'h00, 7'h00, 7'h7F, 7'h41, 7'h41};
      7'd60: g = '{7'h02, 7'h04, 7'h08, 7'h10, 7'h20};
      7'd61: g = '{7'h41, 7'h41, 7'h7F, 7'h00, 7'h00};
      7'd62: g = '{7'h04, 7'h02, 7'h01, 7'h02, 7'h04};
      7'd63: g = '{7'h40, 7'h40, 7'h40, 7'h40, 7'h40};
      7'd64: g = '{7'h00, 7'h01, 7'h02, 7'h04, 7'h00};
      7'd65: g = '{7'h20, 7'h54, 7'h54, 7'h54, 7'h78};
      7'd66: g = '{7'h7F, 7'h48, 7'h44, 7'h44, 7'h38};
      7'd67: g = '{7'h38, 7'h44, 7'h44, 7'h44, 7'h20};
      7'd68: g = '{7'h38, 7'h44, 7'h44, 7'h48, 7'h7F};
      7'd69: g = '{7'h38, 7'h54, 7'h54, 7'h54, 7'h18};
      7'd70: g = '{7'h08, 7'h7E, 7'h09, 7'h01, 7'h02};
      7'd71: g = '{7'h08, 7'h14, 7'h54, 7'h54, 7'h3C};
      7'd72: g = '{7'h7F, 7'h08, 7'h04, 7'h04, 7'h78};
      7'd73: g = '{7'h00, 7'h44, 7'h7D, 7'h40, 7'h00};
      7'd74: g = '{7'h20, 7'h40, 7'h44, 7'h3D, 7'h00};
      7'd75: g = '{7'h00, 7'h7F, 7'h10, 7'h28, 7'h44};
      7'd76: g = '{7'h00, 7'h41, 7'h7F, 7'h40, 7'h00};
      7'd77: g = '{7'h7C, 7'h04, 7'h18, 7'h04, 7'h78};
      7'd78: g = '{7'h7C, 7'h08, 7'h04, 7'h04, 7'h78};
      7'd79: g = '{7'h38, 7'h44, 7'h44, 7'h44, 7'h38};
      7'd80: g = '{7'h7C, 7'h14, 7'h14, 7'h14, 7'h08};
      7'd81: g = '{7'h08, 7'h14, 7'h14, 7'h18, 7'h7C};
      7'd82: g = '{7'h7C, 7'h08, 7'h04, 7'h04, 7'h08};
      7'd83: g = '{7'h48, 7'h54, 7'h54, 7'h54, 7'h20};
      7'd84: g = '{7'h04, 7'h3F, 7'h44, 7'h40, 7'h20};
      7'd85: g = '{7'h3C, 7'h40, 7'h40, 7'h20, 7'h7C};
      7'd86: g = '{7'h1C, 7'h20, 7'h40, 7'h20, 7'h1C};
      7'd87: g = '{7'h3C, 7'h40, 7'h30, 7'h40, 7'h3C};
      7'd88: g = '{7'h44, 7'h28, 7'h10, 7'h28, 7'h44};
      7'd89: g = '{7'h0C, 7'h50, 7'h50, 7'h50, 7'h3C};
      7'd90: g = '{7'h44, 7'h64, 7'h54, 7'h4C, 7'h44};
      7'd91: g = '{7'h00, 7'h08, 7'h36, 7'h41, 7'h00};
      7'd92: g = '{7'h00, 7'h00, 7'h7F, 7'h00, 7'h00};
      7'd93: g = '{7'h00, 7'h41, 7'h36, 7'h08, 7'h00};
      7'd94: g = '{7'h08, 7'h08, 7'h2A, 7'h1C, 7'h08};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/ftpr_front.sv
// Front end: accepts character requests, resolves the cell position, keeps the
// text cursor and fetches the glyph. Depends on ftpr_pkg.
module ftpr_front import ftpr_pkg::*; #(
  parameter int unsigned PANEL_WIDTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_i,
  input  logic        mode_i,
  input  logic [15:0] start_x_i,
  input  logic [15:0] start_y_i,
  input  logic [7:0]  char_code_i,
  output cell_t       cell_o
);

  logic [15:0] cursor_x_q, cursor_x_d;
  logic [15:0] cursor_y_q, cursor_y_d;
  logic [15:0] cx, cy, nx;
  logic [16:0] nx_end;
  logic [7:0]  code;
  logic [6:0]  glyph_idx;

  always_comb begin
    cx = mode_i ? start_x_i : cursor_x_q;
    cy = mode_i ? start_y_i : cursor_y_q;

    // non-printable codes fall back to the space glyph
    code      = (char_code_i < FirstCode || char_code_i > LastCode) ? FirstCode : char_code_i;
    glyph_idx = 7'(code - FirstCode);

    nx     = cx + 16'(CellW);
    nx_end = {1'b0, nx} + 17'(CellW);
    if (nx_end > 17'(PANEL_WIDTH)) begin
      cursor_x_d = '0;
      cursor_y_d = cy + 16'(CellH);
    end else begin
      cursor_x_d = nx;
      cursor_y_d = cy;
    end

    cell_o.cell_x = cx;
    cell_o.cell_y = cy;
    cell_o.glyph  = glyph_rom(glyph_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else if (req_i) begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
    end
  end

endmodule

FILE: rtl/ftpr_queue.sv
// Short FIFO of cell descriptors between the front end and the rasteriser.
// Depends on ftpr_pkg.
module ftpr_queue import ftpr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  cell_t wr_data_i,
  output logic  full_o,
  input  logic  rd_i,
  output cell_t rd_data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cell_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CntW'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(do_wr) - CntW'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/ftpr_back.sv
// Rasteriser: walks each 6x8 cell in row-major order, one pixel per cycle while pop_i keeps up,
// into an output register. Depends on ftpr_pkg.
module ftpr_back import ftpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  cell_t       cell_i,
  input  logic        cell_empty_i,
  output logic        cell_rd_o,
  output logic [15:0] pixel_col_o,
  output logic [15:0] pixel_row_o,
  output logic [15:0] pixel_color_o,
  output logic        last_o,
  output logic        empty_o,
  input  logic        pop_i
);

  cell_t       cell_q;
  logic        cell_valid_q, cell_valid_d;
  logic [2:0]  col_q, col_d;
  logic [2:0]  row_q, row_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] col_out_q, row_out_q, color_out_q;
  logic        last_out_q;
  logic        emit, last_pix, load, on;
  logic [15:0] pix_col, pix_row;

  assign emit     = cell_valid_q && (!out_valid_q || pop_i);
  assign last_pix = (row_q == 3'(CellH - 1)) && (col_q == 3'(CellW - 1));
  assign load     = !cell_empty_i && (!cell_valid_q || (emit && last_pix));
  assign cell_rd_o = load;

  always_comb begin
    // spacing column and bottom row stay background
    on = 1'b0;
    if (col_q < 3'(GlyphCols) && row_q < 3'(CellH - 1)) begin
      on = cell_q.glyph[col_q][row_q];
    end
    pix_col = cell_q.cell_x + 16'(col_q) + 16'(cfg_i.col_offset);
    pix_row = cell_q.cell_y + 16'(row_q) + 16'(cfg_i.row_offset);

    col_d        = col_q;
    row_d        = row_q;
    cell_valid_d = cell_valid_q;
    if (emit) begin
      if (col_q == 3'(CellW - 1)) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
      if (last_pix) begin
        cell_valid_d = 1'b0;
      end
    end
    if (load) begin
      col_d        = '0;
      row_d        = '0;
      cell_valid_d = 1'b1;
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_valid_q <= 1'b0;
      col_q        <= '0;
      row_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      cell_valid_q <= cell_valid_d;
      col_q        <= col_d;
      row_q        <= row_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cell_q <= cell_i;
    end
    if (emit) begin
      col_out_q   <= pix_col;
      row_out_q   <= pix_row;
      color_out_q <= on ? cfg_i.fg_color : cfg_i.bg_color;
      last_out_q  <= last_pix;
    end
  end

  assign pixel_col_o   = col_out_q;
  assign pixel_row_o   = row_out_q;
  assign pixel_color_o = color_out_q;
  assign last_o        = last_out_q;
  assign empty_o       = !out_valid_q;

endmodule

FILE: rtl/font_text_pixel_renderer_core.sv
// Top level of the 5x7 character pixel renderer: configuration registers,
// front end, cell queue and rasteriser. Depends on ftpr_pkg and the ftpr_* modules.
//
//  channel | handshake   | payload
//  --------+-------------+------------------------------------------------
//  input   | push / full | mode_i, start_x_i, start_y_i, char_code_i
//  result  | empty / pop | pixel_col_o, pixel_row_o, pixel_color_o, last_o
//  config  | cfg_we_i    | cfg_idx_i, cfg_wdata_i
//
// Each character request yields 48 pixels, one per clock while pop keeps up;
// the rasteriser's single pixel counter sets the sustained rate of one request
// per 48 pixels. On idle a request is queued, loaded, then first pixel registered.
// A two-entry cell queue lets up to two further requests be taken while a
// cell is drawn; full rises once it holds them. A stalled pop freezes the
// output register and the rasteriser. Reset clears cursor, queue and
// configuration to their defaults; no clearing pass is needed.
module font_text_pixel_renderer_core import ftpr_pkg::*; #(
  parameter int unsigned PANEL_WIDTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic        mode_i,
  input  logic [15:0] start_x_i,
  input  logic [15:0] start_y_i,
  input  logic [7:0]  char_code_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] pixel_col_o,
  output logic [15:0] pixel_row_o,
  output logic [15:0] pixel_color_o,
  output logic        last_o
);

  cfg_t  cfg_q;
  cell_t front_cell, queue_cell;
  logic  accept, queue_empty, queue_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fg_color   <= 16'hFFFF;
      cfg_q.bg_color   <= 16'h0000;
      cfg_q.col_offset <= 8'd2;
      cfg_q.row_offset <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_FG_COLOR:   cfg_q.fg_color   <= cfg_wdata_i;
        REG_BG_COLOR:   cfg_q.bg_color   <= cfg_wdata_i;
        REG_COL_OFFSET: cfg_q.col_offset <= cfg_wdata_i[7:0];
        REG_ROW_OFFSET: cfg_q.row_offset <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  ftpr_front #(
    .PANEL_WIDTH(PANEL_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (accept),
    .mode_i     (mode_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .char_code_i(char_code_i),
    .cell_o     (front_cell)
  );

  ftpr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (push),
    .wr_data_i(front_cell),
    .full_o   (full),
    .rd_i     (queue_rd),
    .rd_data_o(queue_cell),
    .empty_o  (queue_empty)
  );

  ftpr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cell_i       (queue_cell),
    .cell_empty_i (queue_empty),
    .cell_rd_o    (queue_rd),
    .pixel_col_o  (pixel_col_o),
    .pixel_row_o  (pixel_row_o),
    .pixel_color_o(pixel_color_o),
    .last_o       (last_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule

FILE: bench/tb_top.sv
// Regression bench for font_text_pixel_renderer_core: directed and random character
// requests, with every 6x8 cell predicted and checked pixel by pixel.
// Depends on ftpr_pkg and the renderer RTL.
module tb_top;
  import ftpr_pkg::*;

  localparam int unsigned PanelW = 128;

  // 5x7 glyphs, column 0 in the top byte, bit r of a column byte is row r
  localparam logic [39:0] FontRom [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
    40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h08082A1C08
  };

  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = REG_FG_COLOR;
  logic [15:0] cfg_wdata_i = '0;
  logic        push        = 1'b0;
  logic        full;
  logic        mode_i      = 1'b0;
  logic [15:0] start_x_i   = '0;
  logic [15:0] start_y_i   = '0;
  logic [7:0]  char_code_i = '0;
  logic        empty;
  logic        pop         = 1'b0;
  logic [15:0] pixel_col_o;
  logic [15:0] pixel_row_o;
  logic [15:0] pixel_color_o;
  logic        last_o;

  font_text_pixel_renderer_core #(.PANEL_WIDTH(PanelW)) DUT (.*);

  // mirror of the block's registers and text cursor
  logic [15:0] fg_colour  = 16'hFFFF;
  logic [15:0] bg_colour  = 16'h0000;
  logic [7:0]  col_off    = 8'd2;
  logic [7:0]  row_off    = 8'd3;
  logic [15:0] cursor_x   = '0;
  logic [15:0] cursor_y   = '0;

  pixel_t expected_pixels[$];
  int     fail_count  = 0;
  int     pixel_count = 0;
  int     burst_left  = 0;
  int     stall_left  = 0;
  int     stall_kind  = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("font_text_pixel_renderer_core regression: fail");
    $finish;
  end

  // Works out the 48 pixels of one character request and steps the cursor.
  function automatic void draw_cell(input logic mode, input logic [15:0] sx,
                                    input logic [15:0] sy, input logic [7:0] code);
    logic [15:0] cx, cy, nx;
    logic [6:0]  gi;
    logic [7:0]  col_bits;
    logic        lit;
    pixel_t      p;
    cx = mode ? sx : cursor_x;
    cy = mode ? sy : cursor_y;
    gi = (code < FirstCode || code > LastCode) ? 7'd0 : 7'(code - FirstCode);
    for (int r = 0; r < CellH; r++) begin
      for (int c = 0; c < CellW; c++) begin
        lit = 1'b0;
        if (c < GlyphCols) begin
          col_bits = FontRom[gi][(4 - c) * 8 +: 8];
          lit = col_bits[r];
        end
        p.col   = cx + 16'(c) + {8'h00, col_off};
        p.row   = cy + 16'(r) + {8'h00, row_off};
        p.color = lit ? fg_colour : bg_colour;
        p.last  = (r == CellH - 1) && (c == CellW - 1);
        expected_pixels.push_back(p);
      end
    end
    // x wraps at 16 bits first; the panel test is then made without wrap
    nx = cx + 16'(CellW);
    if (32'(nx) + CellW > PanelW) begin
      cursor_x = '0;
      cursor_y = cy + 16'(CellH);
    end else begin
      cursor_x = nx;
      cursor_y = cy;
    end
  endfunction

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(32'h20, 32'h7E));
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 3))
      0, 1:    return 16'($urandom_range(0, PanelW - 1));
      2:       return 16'($urandom_range(16'hFFE0, 16'hFFFF));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_reg_value();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // One character request; the sender runs in bursts with gaps between them.
  task automatic send_char(input logic mode, input logic [15:0] sx, input logic [15:0] sy,
                           input logic [7:0] code);
    int gap;
    @(negedge clk_i);
    push        <= 1'b1;
    mode_i      <= mode;
    start_x_i   <= sx;
    start_y_i   <= sy;
    char_code_i <= code;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    draw_cell(mode, sx, sy, code);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 50);
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_FG_COLOR:   fg_colour = value;
      REG_BG_COLOR:   bg_colour = value;
      REG_COL_OFFSET: col_off   = value[7:0];
      REG_ROW_OFFSET: row_off   = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_defaults();
    send_char(1'b1, 16'd0, 16'd0, "A");
    send_char(1'b0, 16'hFFFF, 16'hFFFF, "g");
    send_char(1'b0, 16'h0000, 16'h0000, "#");
    drain();
  endtask

  task automatic test_cursor_wrap();
    send_char(1'b1, 16'd120, 16'd10, "W");  // next cell would pass the edge
    send_char(1'b0, 16'd0, 16'd0, "x");
    send_char(1'b1, 16'd116, 16'd20, "M");  // next cell ends exactly at the edge
    send_char(1'b0, 16'd0, 16'd0, "m");
    send_char(1'b0, 16'd0, 16'd0, "n");
    send_char(1'b1, 16'd65530, 16'd65530, "@");  // x step wraps to zero, no new line
    send_char(1'b0, 16'd0, 16'd0, "Q");
    send_char(1'b1, 16'hFFFF, 16'hFFFC, 8'h7E);  // x step wraps, no new line; pixel rows wrap past 16 bits
    send_char(1'b0, 16'd0, 16'd0, "Z");
    drain();
  endtask

  task automatic test_unprintable();
    send_char(1'b1, 16'd0, 16'd40, 8'h00);
    send_char(1'b0, 16'd0, 16'd0, 8'h1F);
    send_char(1'b0, 16'd0, 16'd0, 8'h20);
    send_char(1'b0, 16'd0, 16'd0, 8'h21);
    send_char(1'b0, 16'd0, 16'd0, 8'h7E);
    send_char(1'b0, 16'd0, 16'd0, 8'h7F);
    send_char(1'b0, 16'd0, 16'd0, 8'h80);
    send_char(1'b0, 16'd0, 16'd0, 8'hFF);
    drain();
  endtask

  task automatic test_colour_offsets();
    write_reg(REG_FG_COLOR, 16'h0000);
    write_reg(REG_BG_COLOR, 16'hFFFF);
    write_reg(REG_COL_OFFSET, 16'hFFFF);  // upper byte must be dropped
    write_reg(REG_ROW_OFFSET, 16'h00FF);
    send_char(1'b1, 16'hFFF8, 16'hFFF8, "8");
    send_char(1'b0, 16'd0, 16'd0, "B");
    drain();
    write_reg(REG_FG_COLOR, 16'hAAAA);
    write_reg(REG_BG_COLOR, 16'h5555);
    write_reg(REG_COL_OFFSET, 16'h0000);
    write_reg(REG_ROW_OFFSET, 16'hFF00);
    send_char(1'b1, 16'd0, 16'd0, "%");
    send_char(1'b0, 16'd0, 16'd0, "&");
    drain();
  endtask

  // Mostly text runs: a placed character then up to 30 more at the cursor.
  task automatic test_random_text();
    int sent;
    int run;
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      write_reg(REG_FG_COLOR, pick_reg_value());
      write_reg(REG_BG_COLOR, pick_reg_value());
      write_reg(REG_COL_OFFSET, pick_reg_value());
      write_reg(REG_ROW_OFFSET, pick_reg_value());
      sent = 0;
      while (sent < 40) begin
        if ($urandom_range(0, 6) != 0) begin
          send_char(1'b1, pick_coord(), pick_coord(), pick_code());
          run = $urandom_range(1, 30);
          repeat (run) send_char(1'b0, 16'($urandom), 16'($urandom), pick_code());
          sent += run + 1;
        end else begin
          send_char(1'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
          sent++;
        end
      end
    end
    drain();
  endtask

  // receiver stalls in phases: free running, mostly popping, mostly stalled, held
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 150);
    end else begin
      stall_left--;
    end
    case (stall_kind)
      0:       pop <= 1'b1;
      1:       pop <= ($urandom_range(0, 3) != 0);
      2:       pop <= ($urandom_range(0, 3) == 0);
      default: pop <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected pixel col %h row %h color %h last %b",
                   pixel_col_o, pixel_row_o, pixel_color_o, last_o);
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_col_o !== want.col || pixel_row_o !== want.row ||
            pixel_color_o !== want.color || last_o !== want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("pixel %0d: exp col %h row %h color %h last %b, got %h %h %h %b",
                     pixel_count, want.col, want.row, want.color, want.last,
                     pixel_col_o, pixel_row_o, pixel_color_o, last_o);
        end
      end
      pixel_count++;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_cursor_wrap();
    test_unprintable();
    test_colour_offsets();
    test_random_text();
    repeat (50) @(posedge clk_i);  // catch any stray pixels
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("font_text_pixel_renderer_core regression: pass");
    end else begin
      $display("font_text_pixel_renderer_core regression: fail");
    end
    $finish;
  end

endmodule
